FILE: src/wds_pkg.sv
// ----------------------------------------------------------------------------
// wds_pkg
// Shared types, operation codes and defaults of the word dictionary search unit.
// ----------------------------------------------------------------------------
package wds_pkg;

	localparam int NUM_WORDS_DEF  = 256;
	localparam int WORD_CHARS_DEF = 8;
	localparam int EXACT_BELOW    = 6;
	localparam int COUNT_W        = 9;

	localparam logic [2:0] OP_WRITE     = 3'd0;
	localparam logic [2:0] OP_FIND_TEXT = 3'd1;
	localparam logic [2:0] OP_IDX_CLASS = 3'd2;
	localparam logic [2:0] OP_IDX_MASK  = 3'd3;
	localparam logic [2:0] OP_CHECK     = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  slot;
		logic [63:0] entry_text;
		logic [3:0]  entry_length;
		logic [7:0]  entry_index;
		logic [7:0]  entry_class;
		logic [63:0] query_text;
		logic [7:0]  query_length;
		logic [7:0]  lookup_index;
		logic [7:0]  lookup_class;
		logic [7:0]  class_mask;
	} request_t;

	typedef struct packed {
		logic       found;
		logic [7:0] found_slot;
		logic [7:0] found_index;
		logic [7:0] found_class;
	} result_t;

endpackage

FILE: src/word_dictionary_search_unit.sv
// ----------------------------------------------------------------------------
// word_dictionary_search_unit
// Dictionary store with first-hit linear search over slots 0..min(word_count, NUM_WORDS)-1.
// ----------------------------------------------------------------------------
// channel    dir  handshake                       payload
// request    in   request_valid / request_stall   wds_pkg::request_t
// result     out  result_valid / result_stall     wds_pkg::result_t
// cfg        in   cfg_write                       cfg_data (word_count)
//
// Writes and undefined operations go straight to the done state; a search reads slots
// 0..n-1, n = min(word_count, NUM_WORDS), one memory read per cycle, ending at first hit.
// Reset clears control state and word_count; entries stay undefined until written.
// A new transaction is taken while a finished result waits under result_stall.
// ----------------------------------------------------------------------------
module word_dictionary_search_unit #(
	parameter int NUM_WORDS  = wds_pkg::NUM_WORDS_DEF,
	parameter int WORD_CHARS = wds_pkg::WORD_CHARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         request_valid,
	output logic                         request_stall,
	input  wds_pkg::request_t            request,
	output logic                         result_valid,
	input  logic                         result_stall,
	output wds_pkg::result_t             result,
	input  logic                         cfg_write,
	input  logic [wds_pkg::COUNT_W-1:0]  cfg_data
);

	localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CW = $clog2(NUM_WORDS + 1);
	localparam int TW = WORD_CHARS * 8;
	localparam int DW = TW + 4 + 8 + 8;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                  state_q;
	logic [wds_pkg::COUNT_W-1:0] word_count_q;
	wds_pkg::request_t           qry_q;
	wds_pkg::result_t            res_next_q;
	wds_pkg::result_t            res_q;
	logic                        res_valid_q;
	logic [CW-1:0]               scan_q;
	logic                        valid_s1;
	logic [AW-1:0]               slot_s1;

	logic [CW-1:0] n;
	logic          accept;
	logic          issue;
	logic          out_free;
	logic          wr_en;
	logic [3:0]    wr_len;
	logic [DW-1:0] wr_data;
	logic [DW-1:0] rd_data;
	logic          hit;
	logic          is_search;

	assign n = (32'(word_count_q) > NUM_WORDS) ? CW'(NUM_WORDS) : CW'(word_count_q);

	assign request_stall = (state_q != ST_IDLE);
	assign accept        = request_valid && !request_stall;
	assign issue         = (state_q == ST_SCAN) && (scan_q != n);
	assign out_free      = !res_valid_q || !result_stall;
	assign is_search     = (request.operation == wds_pkg::OP_FIND_TEXT) ||
	                       (request.operation == wds_pkg::OP_IDX_CLASS) ||
	                       (request.operation == wds_pkg::OP_IDX_MASK)  ||
	                       (request.operation == wds_pkg::OP_CHECK);

	assign wr_en   = accept && (request.operation == wds_pkg::OP_WRITE) &&
	                 (32'(request.slot) < NUM_WORDS);
	assign wr_len  = (request.entry_length > 4'(WORD_CHARS)) ? 4'(WORD_CHARS)
	                                                        : request.entry_length;
	assign wr_data = {request.entry_text[TW-1:0], wr_len, request.entry_index,
	                  request.entry_class};

	wds_mem #(
		.DEPTH (NUM_WORDS),
		.AW    (AW),
		.DW    (DW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(request.slot)),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (scan_q[AW-1:0]),
		.rd_data (rd_data)
	);

	wds_match #(
		.WORD_CHARS (WORD_CHARS)
	) u_match (
		.qry        (qry_q),
		.ent_text   (rd_data[DW-1 -: TW]),
		.ent_length (rd_data[19:16]),
		.ent_index  (rd_data[15:8]),
		.ent_class  (rd_data[7:0]),
		.hit        (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
		end else if (cfg_write) begin
			word_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q <= request;
		end
		slot_s1 <= scan_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			res_next_q  <= '0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					valid_s1 <= 1'b0;
					scan_q   <= '0;
					if (accept) begin
						res_next_q <= '0;
						state_q    <= (is_search && n != '0) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (valid_s1 && hit) begin
						res_next_q.found <= 1'b1;
						if (qry_q.operation != wds_pkg::OP_CHECK) begin
							res_next_q.found_slot  <= 8'(slot_s1);
							res_next_q.found_index <= rd_data[15:8];
							res_next_q.found_class <= rd_data[7:0];
						end
						valid_s1 <= 1'b0;
						state_q  <= ST_DONE;
					end else if (!issue && !valid_s1) begin
						state_q <= ST_DONE;
					end else begin
						valid_s1 <= issue;
						if (issue) begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_q       <= res_next_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTH
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == ST_SCAN)
		else $error("read pipeline active outside scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_q <= n)
		else $error("scan pointer beyond word count");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |->
			result.found_slot == 8'd0 && result.found_index == 8'd0 &&
			result.found_class == 8'd0)
		else $error("miss result carries nonzero fields");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside done state");
`endif

endmodule

FILE: src/wds_mem.sv
// ----------------------------------------------------------------------------
// wds_mem
// Dictionary entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wds_mem #(
	parameter int DEPTH = wds_pkg::NUM_WORDS_DEF,
	parameter int AW    = 8,
	parameter int DW    = 84
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/wds_match.sv
// ----------------------------------------------------------------------------
// wds_match
// Compares one stored entry against the held query.
// ----------------------------------------------------------------------------
module wds_match #(
	parameter int WORD_CHARS = wds_pkg::WORD_CHARS_DEF
) (
	input  wds_pkg::request_t        qry,
	input  logic [WORD_CHARS*8-1:0]  ent_text,
	input  logic [3:0]               ent_length,
	input  logic [7:0]               ent_index,
	input  logic [7:0]               ent_class,
	output logic                     hit
);

	logic text_hit;
	logic idx_eq;
	logic mask_hit;

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	always_comb begin
		logic       stop;
		logic [7:0] a;
		logic [7:0] b;
		text_hit = 1'b1;
		stop     = 1'b0;
		if (ent_length < 4'(wds_pkg::EXACT_BELOW) && {4'b0, ent_length} != qry.query_length) begin
			text_hit = 1'b0;
		end
		for (int i = 0; i < WORD_CHARS; i++) begin
			a = fold(ent_text[8*i +: 8]);
			b = (8'(i) < qry.query_length) ? fold(qry.query_text[8*i +: 8]) : 8'h00;
			if (!stop && 4'(i) < ent_length) begin
				if (a != b) begin
					text_hit = 1'b0;
					stop     = 1'b1;
				end else if (a == 8'h00) begin
					stop = 1'b1;
				end
			end
		end
	end

	assign idx_eq   = (ent_index == qry.lookup_index);
	assign mask_hit = |(ent_class & qry.class_mask);

	always_comb begin
		unique case (qry.operation)
			wds_pkg::OP_FIND_TEXT: hit = text_hit;
			wds_pkg::OP_IDX_CLASS: hit = idx_eq && (ent_class == qry.lookup_class);
			wds_pkg::OP_IDX_MASK:  hit = idx_eq && mask_hit;
			wds_pkg::OP_CHECK:     hit = idx_eq && mask_hit && text_hit;
			default:               hit = 1'b0;
		endcase
	end

endmodule
